// ===== sv/md5_pkg.sv =====
// Shared types, constants and round tables for the MD5 digest block.
`default_nettype none

package md5_pkg;

  // Initial chaining vector.
  localparam logic [31:0] IV_A = 32'h67452301;
  localparam logic [31:0] IV_B = 32'hefcdab89;
  localparam logic [31:0] IV_C = 32'h98badcfe;
  localparam logic [31:0] IV_D = 32'h10325476;

  // Padding marker byte and the word slots that carry the message length.
  localparam logic [31:0] PAD_MARK  = 32'h00000080;
  localparam logic [3:0]  LEN_LO_WD = 4'd14;
  localparam logic [3:0]  LEN_HI_WD = 4'd15;
  localparam logic [3:0]  LAST_WD   = 4'd15;
  localparam logic [1:0]  LAST_IDX  = 2'd3;

  // Message input item.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       end_of_message;
  } msg_t;

  // Digest output item.
  typedef struct packed {
    logic [31:0] digest_word;
    logic [1:0]  word_index;
    logic        last_word;
  } dig_t;

  // Word write from the front end into the block queue.
  typedef struct packed {
    logic        en;
    logic [3:0]  addr;
    logic [31:0] data;
    logic        push;
    logic        last_blk;
  } md5_wr_t;

  // Read request from the round engine into the block queue.
  typedef struct packed {
    logic [3:0] addr;
    logic       pop;
  } md5_rd_t;

  // State of the oldest queued block.
  typedef struct packed {
    logic valid;
    logic last_blk;
  } md5_head_t;

  // Round constant for each of the 64 rounds.
  function automatic logic [31:0] k_const(input logic [5:0] r);
    logic [31:0] k;
    case (r)
      6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
      6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
      6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
      6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
      6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
      6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
      6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
      6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
      6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
      6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
      6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
      6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
      6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
      6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
      6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
      6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
      6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
      6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
      6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
      6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
      6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
      6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
      6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

  // Left rotate amount, chosen by round group and round within the group of four.
  function automatic logic [4:0] rot_amt(input logic [5:0] r);
    logic [4:0] s;
    case ({r[5:4], r[1:0]})
      4'd0:  s = 5'd7;   4'd1:  s = 5'd12;  4'd2:  s = 5'd17;  4'd3:  s = 5'd22;
      4'd4:  s = 5'd5;   4'd5:  s = 5'd9;   4'd6:  s = 5'd14;  4'd7:  s = 5'd20;
      4'd8:  s = 5'd4;   4'd9:  s = 5'd11;  4'd10: s = 5'd16;  4'd11: s = 5'd23;
      4'd12: s = 5'd6;   4'd13: s = 5'd10;  4'd14: s = 5'd15;  4'd15: s = 5'd21;
      default: s = 5'd7;
    endcase
    return s;
  endfunction

  // Index of the message word consumed by a round.
  function automatic logic [3:0] msg_index(input logic [5:0] r);
    logic [3:0] r4;
    logic [3:0] g;
    r4 = r[3:0];
    case (r[5:4])
      2'd0:    g = r4;
      2'd1:    g = 4'(r4 * 4'd5 + 4'd1);
      2'd2:    g = 4'(r4 * 4'd3 + 4'd5);
      default: g = 4'(r4 * 4'd7);
    endcase
    return g;
  endfunction

  // 32-bit rotate left by a nonzero amount.
  function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] s);
    return (x << s) | (x >> (6'd32 - {1'b0, s}));
  endfunction

endpackage

`default_nettype wire

// ===== sv/md5_front.sv =====
// Front end: packs message bytes into words and generates the padding and length.
`default_nettype none

module md5_front (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            msg_valid,
  output logic                 msg_stall,
  input  md5_pkg::msg_t        msg,
  input  wire logic            full,
  output md5_pkg::md5_wr_t     wr
);
  import md5_pkg::*;

  typedef enum logic {ST_BYTE, ST_PAD} state_t;

  state_t      state;
  logic [63:0] bit_count;
  logic [31:0] acc;
  logic [3:0]  widx;
  logic        extra;
  logic        first;

  logic        take;
  logic [63:0] count_next;
  logic [31:0] byte_word;
  logic [3:0]  pad_word;
  logic [4:0]  lane_shift;

  // Items are taken only while collecting bytes and a block slot is free.
  assign msg_stall  = (state != ST_BYTE) || full;
  assign take       = msg_valid && !msg_stall;
  assign count_next = bit_count + 64'd8;
  assign lane_shift = {bit_count[4:3], 3'b000};
  assign byte_word  = acc | (32'(msg.data_byte) << lane_shift);
  assign pad_word   = msg.byte_valid ? count_next[8:5] : bit_count[8:5];

  // Word writes into the queue: completed byte words, then the padding words.
  always_comb begin
    wr = '0;
    case (state)
      ST_BYTE: begin
        if (take && msg.byte_valid && (bit_count[4:3] == 2'd3)) begin
          wr.en   = 1'b1;
          wr.addr = bit_count[8:5];
          wr.data = byte_word;
          wr.push = (bit_count[8:5] == LAST_WD);
        end
      end
      ST_PAD: begin
        if (!full) begin
          wr.en   = 1'b1;
          wr.addr = widx;
          if (first) begin
            wr.data = acc | (PAD_MARK << lane_shift);
          end else if (!extra && (widx == LEN_LO_WD)) begin
            wr.data = bit_count[31:0];
          end else if (!extra && (widx == LEN_HI_WD)) begin
            wr.data = bit_count[63:32];
          end else begin
            wr.data = '0;
          end
          wr.push     = (widx == LAST_WD);
          wr.last_blk = !extra;
        end
      end
      default: ;
    endcase
  end

  // Byte counting and padding sequence.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_BYTE;
      bit_count <= '0;
      acc       <= '0;
      widx      <= '0;
      extra     <= 1'b0;
      first     <= 1'b0;
    end else begin
      case (state)
        ST_BYTE: begin
          if (take) begin
            if (msg.byte_valid) begin
              bit_count <= count_next;
              acc       <= (bit_count[4:3] == 2'd3) ? '0 : byte_word;
            end
            if (msg.end_of_message) begin
              state <= ST_PAD;
              first <= 1'b1;
              widx  <= pad_word;
              // A marker in the last two words pushes the length into a second block.
              extra <= (pad_word >= LEN_LO_WD);
            end
          end
        end
        ST_PAD: begin
          if (!full) begin
            first <= 1'b0;
            acc   <= '0;
            widx  <= widx + 4'd1;
            if (widx == LAST_WD) begin
              extra <= 1'b0;
              if (!extra) begin
                state     <= ST_BYTE;
                bit_count <= '0;
              end
            end
          end
        end
        default: state <= ST_BYTE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== sv/md5_queue.sv =====
// Two-slot block queue between the front end and the round engine.
`default_nettype none

module md5_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  md5_pkg::md5_wr_t    wr,
  output logic                full,
  input  md5_pkg::md5_rd_t    rd,
  output md5_pkg::md5_head_t  head,
  output logic [31:0]         rd_data
);
  import md5_pkg::*;

  logic [31:0] mem [32];
  logic [1:0]  count;
  logic        wr_slot;
  logic        rd_slot;
  logic [1:0]  last_flag;

  assign full          = (count == 2'd2);
  assign head.valid    = (count != 2'd0);
  assign head.last_blk = last_flag[rd_slot];

  // Block memory: one word written and one word read each cycle.
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[{wr_slot, wr.addr}] <= wr.data;
    end
    rd_data <= mem[{rd_slot, rd.addr}];
  end

  // Slot pointers and occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      wr_slot   <= 1'b0;
      rd_slot   <= 1'b0;
      last_flag <= '0;
    end else begin
      if (wr.push) begin
        last_flag[wr_slot] <= wr.last_blk;
        wr_slot            <= !wr_slot;
      end
      if (rd.pop) begin
        rd_slot <= !rd_slot;
      end
      if (wr.push && !rd.pop) begin
        count <= count + 2'd1;
      end else if (!wr.push && rd.pop) begin
        count <= count - 2'd1;
      end
    end
  end

  // The front end never writes into an occupied slot.
  a_no_write_full: assert property (@(posedge clk) disable iff (rst) wr.en |-> !full)
    else $error("block write while both slots are occupied");

  // The round engine only releases a block that is present.
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    rd.pop |-> (count != 2'd0))
    else $error("block released from an empty queue");

  // A push without a release adds exactly one block.
  a_push_count: assert property (@(posedge clk) disable iff (rst)
    (wr.push && !rd.pop) |=> (count == $past(count) + 2'd1))
    else $error("queue occupancy did not follow a push");

endmodule

`default_nettype wire

// ===== sv/md5_round.sv =====
// Round engine: 64 rounds per block, chaining update and digest output register.
`default_nettype none

module md5_round (
  input  wire logic           clk,
  input  wire logic           rst,
  input  md5_pkg::md5_head_t  head,
  input  wire logic [31:0]    rd_data,
  output md5_pkg::md5_rd_t    rd,
  output logic                dig_valid,
  input  wire logic           dig_stall,
  output md5_pkg::dig_t       dig
);
  import md5_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_ROUND, ST_ADD, ST_OUT} state_t;

  state_t      state;
  logic [31:0] chain [4];
  logic [31:0] a, b, c, d;
  logic [5:0]  rnd;
  logic [1:0]  idx;

  logic [31:0] f;
  logic [31:0] sum;
  logic [31:0] rot;
  logic [1:0]  idx_next;

  // Round function for the current group.
  always_comb begin
    case (rnd[5:4])
      2'd0:    f = (b & c) | (~b & d);
      2'd1:    f = (d & b) | (c & ~d);
      2'd2:    f = b ^ c ^ d;
      default: f = c ^ (b | ~d);
    endcase
    sum = a + f + k_const(rnd) + rd_data;
    rot = rotl(sum, rot_amt(rnd));
  end

  // The message word for the next round is fetched during the current round, through the registered queue read.
  assign rd.addr  = (state == ST_ROUND) ? msg_index(6'(rnd + 6'd1)) : 4'd0;
  assign rd.pop   = (state == ST_ADD);
  assign idx_next = idx + 2'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      chain[0]  <= IV_A;
      chain[1]  <= IV_B;
      chain[2]  <= IV_C;
      chain[3]  <= IV_D;
      a         <= '0;
      b         <= '0;
      c         <= '0;
      d         <= '0;
      rnd       <= '0;
      idx       <= '0;
      dig_valid <= 1'b0;
      dig       <= '0;
    end else begin
      case (state)
        // Start a block as soon as one is queued.
        ST_IDLE: begin
          if (head.valid) begin
            a     <= chain[0];
            b     <= chain[1];
            c     <= chain[2];
            d     <= chain[3];
            rnd   <= '0;
            state <= ST_ROUND;
          end
        end
        // One round per cycle.
        ST_ROUND: begin
          a   <= d;
          d   <= c;
          c   <= b;
          b   <= b + rot;
          rnd <= rnd + 6'd1;
          if (rnd == 6'd63) begin
            state <= ST_ADD;
          end
        end
        // Fold the working words into the chain; the last block opens the digest.
        ST_ADD: begin
          chain[0] <= chain[0] + a;
          chain[1] <= chain[1] + b;
          chain[2] <= chain[2] + c;
          chain[3] <= chain[3] + d;
          if (head.last_blk) begin
            dig_valid       <= 1'b1;
            dig.digest_word <= chain[0] + a;
            dig.word_index  <= 2'd0;
            dig.last_word   <= 1'b0;
            idx             <= '0;
            state           <= ST_OUT;
          end else begin
            state <= ST_IDLE;
          end
        end
        // Hand out the four digest words, then restart from the initial vector.
        ST_OUT: begin
          if (!dig_stall) begin
            if (idx == LAST_IDX) begin
              dig_valid <= 1'b0;
              chain[0]  <= IV_A;
              chain[1]  <= IV_B;
              chain[2]  <= IV_C;
              chain[3]  <= IV_D;
              state     <= ST_IDLE;
            end else begin
              idx             <= idx_next;
              dig.digest_word <= chain[idx_next];
              dig.word_index  <= idx_next;
              dig.last_word   <= (idx_next == LAST_IDX);
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== sv/md5_message_digest.sv =====
// MD5 message digest engine, top level.
//
// The message channel (msg_valid, msg_stall, msg) takes one item per cycle
// while msg_stall is low: a message byte, an end-of-message mark, or both (the
// byte counts first). An item with neither flag is taken and ignored. The
// digest channel (dig_valid, dig_stall, dig) gives the four chaining words A,
// B, C, D, with last_word set on D, after the final block of each message.
// Bytes are packed into a two-slot block queue. For each 64-byte block the
// round engine takes a fetch step, 64 rounds at one round per cycle and one
// chaining add, and starts the next block only after that add; the front end
// stalls while both slots hold blocks and while it writes the padding.
// After the end mark the front end writes padding at one word per cycle while a
// slot is free, from the marker word through word 15, and through a second
// block when the length spills into one. The first digest word is registered
// in the final chaining add, and the rest follow one a cycle without a stall.
// A stall on the digest channel holds the current word; the front end keeps
// filling the queue meanwhile.
// Reset empties the queue, clears the byte count and loads the initial vector.
`default_nettype none

module md5_message_digest (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     msg_valid,
  output logic          msg_stall,
  input  md5_pkg::msg_t msg,
  output logic          dig_valid,
  input  wire logic     dig_stall,
  output md5_pkg::dig_t dig
);
  import md5_pkg::*;

  md5_wr_t     wr;
  md5_rd_t     rd;
  md5_head_t   head;
  logic        full;
  logic [31:0] rd_data;

  md5_front u_front (
    .clk       (clk),
    .rst       (rst),
    .msg_valid (msg_valid),
    .msg_stall (msg_stall),
    .msg       (msg),
    .full      (full),
    .wr        (wr)
  );

  md5_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (wr),
    .full    (full),
    .rd      (rd),
    .head    (head),
    .rd_data (rd_data)
  );

  md5_round u_round (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .rd_data   (rd_data),
    .rd        (rd),
    .dig_valid (dig_valid),
    .dig_stall (dig_stall),
    .dig       (dig)
  );

endmodule

`default_nettype wire
